[design/cspdp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cspdp_pkg
// Shared constants and controller/datapath handshake types for the
// skip-checkpoint route length engine.
// ---------------------------------------------------------------------------
package cspdp_pkg;

    // default sizing of the top level
    localparam int MAX_SKIPS_DEF  = 15;
    localparam int COORD_BITS_DEF = 16;
    localparam int COST_BITS_DEF  = 32;

    // fixed field widths
    localparam int SKIP_REG_BITS = 4;
    localparam int OUT_BITS      = 32;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture the item and arm the update counters
        logic step;     // issue one distance-add-min update
        logic seed;     // first point of a route: row is zero at column 0
        logic finish;   // commit the point or emit the result
    } t_ctl_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic ps_zero;    // window holds no point of the current route
        logic iter_last;  // the update issued now is the final one
        logic pipe_busy;  // updates still in flight
        logic out_free;   // output register can take a result
        logic last;       // captured item closes the route
    } t_ctl_sts;

endpackage
`default_nettype wire

[design/cspdp_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cspdp_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ---------------------------------------------------------------------------
module cspdp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[design/cspdp_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cspdp_ctrl
// Sequencer: takes one item, seeds a route's first point or runs the row update
// loop, drains the pipeline, then commits the point or emits a result.
// ---------------------------------------------------------------------------
module cspdp_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire cspdp_pkg::t_ctl_sts i_sts,
    output cspdp_pkg::t_ctl_cmd      o_cmd
);
    import cspdp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_SEED,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   w_accept;

    assign w_accept   = i_in_valid && r_ready;
    assign o_in_ready = r_ready;

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.ps_zero ? S_SEED : S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_sts.iter_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_FINISH;
                end
            end
            S_SEED: begin
                o_cmd.seed = 1'b1;
                n_state    = S_FINISH;
            end
            S_FINISH: begin
                if (!i_sts.last || i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    // an item is only taken with no update in flight
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !i_sts.pipe_busy)
        else $error("item accepted while updates are in flight");

    // a point is committed only after its row is fully written
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> !i_sts.pipe_busy && !o_cmd.step)
        else $error("finish while the update pipeline is busy");

    // the update loop always ends with a drain before finishing
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step && i_sts.iter_last) |=> !o_cmd.step && !o_cmd.finish)
        else $error("loop end not followed by drain");

endmodule
`default_nettype wire

[design/cspdp_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cspdp_dpath
// Datapath: point window, per-slot skip limits, cost row RAM addressed by
// circular slot and skip column, a three-stage distance-add-min unit, the
// running minimum and the output register.
// ---------------------------------------------------------------------------
module cspdp_dpath #(
    parameter int MAX_SKIPS  = cspdp_pkg::MAX_SKIPS_DEF,
    parameter int COORD_BITS = cspdp_pkg::COORD_BITS_DEF,
    parameter int COST_BITS  = cspdp_pkg::COST_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [cspdp_pkg::SKIP_REG_BITS-1:0] i_cfg_wdata,
    input  wire logic [COORD_BITS-1:0]               i_point_x,
    input  wire logic [COORD_BITS-1:0]               i_point_y,
    input  wire logic                                i_last_point,
    input  wire cspdp_pkg::t_ctl_cmd                 i_cmd,
    output cspdp_pkg::t_ctl_sts                      o_sts,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic [cspdp_pkg::OUT_BITS-1:0]           o_out_data
);
    import cspdp_pkg::*;

    localparam int WIN   = MAX_SKIPS + 1;
    localparam int NSLOT = WIN + 1;
    localparam int SW    = $clog2(NSLOT);
    localparam int CW    = $clog2(WIN);
    localparam int AW    = SW + CW;
    localparam int DEPTH = NSLOT * (2 ** CW);
    localparam int DW    = COORD_BITS + 2;

    localparam logic [COST_BITS-1:0] INF = '1;

    // configuration
    logic [SKIP_REG_BITS-1:0] r_max_skips;
    logic [CW-1:0]            w_k_eff;

    // route state
    logic [COORD_BITS-1:0] r_xwin  [NSLOT];
    logic [COORD_BITS-1:0] r_ywin  [NSLOT];
    logic [CW-1:0]         r_slotk [NSLOT];
    logic [SW-1:0]         r_head;
    logic [SW-1:0]         r_ps;
    logic [SW-1:0]         w_new_slot;

    // current item
    logic [COORD_BITS-1:0] r_cur_x;
    logic [COORD_BITS-1:0] r_cur_y;
    logic                  r_last;
    logic                  r_first;
    logic [CW-1:0]         r_k;

    // update loop counters
    logic [CW-1:0] r_j;
    logic [CW-1:0] r_col;
    logic [SW-1:0] r_p;
    logic [SW-1:0] r_rd_slot;
    logic          w_grp_end;

    // distance of the current point to the window point being read
    logic [COORD_BITS:0]   w_dx;
    logic [COORD_BITS:0]   w_dy;
    logic [COORD_BITS:0]   w_adx;
    logic [COORD_BITS:0]   w_ady;
    logic [DW-1:0]         w_dsum;
    logic [COST_BITS-1:0]  w_dist;

    // pipeline stages
    logic                 r_s1_valid;
    logic                 r_s1_first;
    logic                 r_s1_end;
    logic                 r_s1_colok;
    logic [CW-1:0]        r_s1_j;
    logic [COST_BITS-1:0] r_s1_dist;
    logic [COST_BITS-1:0] w_ram_q;
    logic [COST_BITS-1:0] w_s1_c;
    logic [COST_BITS:0]   w_s1_sum;
    logic                 r_s2_valid;
    logic                 r_s2_first;
    logic                 r_s2_end;
    logic [CW-1:0]        r_s2_j;
    logic [COST_BITS-1:0] r_s2_cand;
    logic [COST_BITS-1:0] r_acc;
    logic [COST_BITS-1:0] w_acc_n;
    logic                 r_s3_valid;
    logic [CW-1:0]        r_s3_j;
    logic [COST_BITS-1:0] r_s3_val;
    logic [COST_BITS-1:0] r_best;

    // RAM ports
    logic                 w_ram_we;
    logic [AW-1:0]        w_ram_waddr;
    logic [COST_BITS-1:0] w_ram_wdata;
    logic [AW-1:0]        w_ram_raddr;

    // output register
    logic                r_out_valid;
    logic [OUT_BITS-1:0] r_out_data;
    logic [OUT_BITS-1:0] w_best_out;

    // effective skip limit
    always_comb begin
        if ({3'b000, r_max_skips} > 7'(MAX_SKIPS)) begin
            w_k_eff = CW'(MAX_SKIPS);
        end else begin
            w_k_eff = CW'(r_max_skips);
        end
    end

    // slot that the new row goes into
    assign w_new_slot = (r_head == SW'(NSLOT - 1)) ? '0 : r_head + 1'b1;

    // group ends at column zero or at the oldest point held
    assign w_grp_end = (r_col == '0) || (r_p == r_ps);

    // manhattan distance, saturated to the cost width
    assign w_dx   = {r_cur_x[COORD_BITS-1], r_cur_x}
                  - {r_xwin[r_rd_slot][COORD_BITS-1], r_xwin[r_rd_slot]};
    assign w_dy   = {r_cur_y[COORD_BITS-1], r_cur_y}
                  - {r_ywin[r_rd_slot][COORD_BITS-1], r_ywin[r_rd_slot]};
    assign w_adx  = w_dx[COORD_BITS] ? ((COORD_BITS + 1)'(0) - w_dx) : w_dx;
    assign w_ady  = w_dy[COORD_BITS] ? ((COORD_BITS + 1)'(0) - w_dy) : w_dy;
    assign w_dsum = {1'b0, w_adx} + {1'b0, w_ady};

    generate
        if (DW <= COST_BITS) begin : g_dist_fit
            assign w_dist = COST_BITS'(w_dsum);
        end else begin : g_dist_clamp
            assign w_dist = (|w_dsum[DW-1:COST_BITS]) ? INF : w_dsum[COST_BITS-1:0];
        end
    endgenerate

    // result width conversion
    generate
        if (COST_BITS > OUT_BITS) begin : g_out_clamp
            assign w_best_out = (|r_best[COST_BITS-1:OUT_BITS]) ? '1
                              : r_best[OUT_BITS-1:0];
        end else begin : g_out_fit
            assign w_best_out = OUT_BITS'(r_best);
        end
    endgenerate

    // stage 1: columns beyond the row's skip limit read as unreachable
    assign w_s1_c   = r_s1_colok ? w_ram_q : INF;
    assign w_s1_sum = {1'b0, w_s1_c} + {1'b0, r_s1_dist};

    // stage 2: running minimum of the row entry
    always_comb begin
        if (r_s2_first || (r_s2_cand < r_acc)) begin
            w_acc_n = r_s2_cand;
        end else begin
            w_acc_n = r_acc;
        end
    end

    // RAM port selection: seed write or finished row entry
    assign w_ram_raddr = {r_rd_slot, r_col};
    always_comb begin
        if (i_cmd.seed) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = {w_new_slot, CW'(0)};
            w_ram_wdata = '0;
        end else begin
            w_ram_we    = r_s3_valid;
            w_ram_waddr = {w_new_slot, r_s3_j};
            w_ram_wdata = r_s3_val;
        end
    end

    cspdp_ram #(
        .WIDTH (COST_BITS),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_q)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_skips <= '0;
            r_head      <= '0;
            r_ps        <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_skips <= i_cfg_wdata;
            end
            r_s1_valid <= i_cmd.step;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid && r_s2_end;
            if (i_cmd.finish) begin
                if (r_last) begin
                    r_ps <= '0;
                end else begin
                    r_head <= w_new_slot;
                    if (r_ps != SW'(WIN)) begin
                        r_ps <= r_ps + 1'b1;
                    end
                end
            end
            if (i_cmd.finish && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        // item capture and loop arming
        if (i_cmd.load) begin
            r_cur_x   <= i_point_x;
            r_cur_y   <= i_point_y;
            r_last    <= i_last_point;
            r_first   <= (r_ps == '0);
            r_k       <= w_k_eff;
            r_j       <= '0;
            r_col     <= '0;
            r_p       <= SW'(1);
            r_rd_slot <= r_head;
        end else if (i_cmd.step) begin
            if (w_grp_end) begin
                r_j       <= r_j + 1'b1;
                r_col     <= r_j + 1'b1;
                r_p       <= SW'(1);
                r_rd_slot <= r_head;
            end else begin
                r_col     <= r_col - 1'b1;
                r_p       <= r_p + 1'b1;
                r_rd_slot <= (r_rd_slot == '0) ? SW'(NSLOT - 1) : r_rd_slot - 1'b1;
            end
        end

        // stage 1
        r_s1_first <= (r_p == SW'(1));
        r_s1_end   <= w_grp_end;
        r_s1_j     <= r_j;
        r_s1_dist  <= w_dist;
        r_s1_colok <= (r_col <= r_slotk[r_rd_slot]);

        // stage 2: saturating add
        r_s2_first <= r_s1_first;
        r_s2_end   <= r_s1_end;
        r_s2_j     <= r_s1_j;
        r_s2_cand  <= w_s1_sum[COST_BITS] ? INF : w_s1_sum[COST_BITS-1:0];

        // stage 3: finished row entry
        if (r_s2_valid) begin
            r_acc <= w_acc_n;
        end
        r_s3_j   <= r_s2_j;
        r_s3_val <= w_acc_n;

        // least entry of the new row
        if (i_cmd.load) begin
            r_best <= INF;
        end else if (i_cmd.seed) begin
            r_best <= '0;
        end else if (r_s3_valid && (r_s3_val < r_best)) begin
            r_best <= r_s3_val;
        end

        // window commit
        if (i_cmd.finish && !r_last) begin
            r_xwin[w_new_slot]  <= r_cur_x;
            r_ywin[w_new_slot]  <= r_cur_y;
            r_slotk[w_new_slot] <= r_first ? '0 : r_k;
        end

        // result
        if (i_cmd.finish && r_last) begin
            r_out_data <= w_best_out;
        end
    end

    // status to the controller
    always_comb begin
        o_sts           = '0;
        o_sts.ps_zero   = (r_ps == '0);
        o_sts.iter_last = w_grp_end && (r_j == r_k);
        o_sts.pipe_busy = r_s1_valid || r_s2_valid || r_s3_valid;
        o_sts.out_free  = !r_out_valid || i_out_ready;
        o_sts.last      = r_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // reads stay within the held points of the route
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_p != '0) && (r_p <= r_ps))
        else $error("update reads a point outside the window");

    // column and row index stay within the skip limit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_col <= r_j) && (r_j <= r_k))
        else $error("update column beyond skip limit");

    // the new row slot is never one being read
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_rd_slot != w_new_slot))
        else $error("read slot collides with the row being written");

    // seeding only happens on an empty route
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.seed |-> (r_ps == '0) && !o_sts.pipe_busy)
        else $error("seed on a route that already holds points");

endmodule
`default_nettype wire

[design/checkpoint_skip_path_dp_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// checkpoint_skip_path_dp_core
// Least Manhattan route length from first to last point, skipping at most a
// configured number of intermediate points.
// One item at a time; the first point of a route is seeded, any other point
// runs its row update loop through the single distance-add-min unit, which
// makes one update per cycle against the cost row RAM.
// The result is registered and held until taken; the next item is taken
// while it waits. Synchronous active-low reset; no clearing pass is needed.
// ---------------------------------------------------------------------------
module checkpoint_skip_path_dp_core #(
    parameter int MAX_SKIPS  = cspdp_pkg::MAX_SKIPS_DEF,
    parameter int COORD_BITS = cspdp_pkg::COORD_BITS_DEF,
    parameter int COST_BITS  = cspdp_pkg::COST_BITS_DEF,
    parameter int TDW        = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [cspdp_pkg::SKIP_REG_BITS-1:0] i_cfg_wdata,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // point_x, point_y, zero fill
    input  wire logic [TDW-1:0]                      s_axis_tdata,
    input  wire logic                                s_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // min_length
    output logic [cspdp_pkg::OUT_BITS-1:0]           m_axis_tdata
);
    import cspdp_pkg::*;

    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;

    // sequencer
    cspdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath
    cspdp_dpath #(
        .MAX_SKIPS  (MAX_SKIPS),
        .COORD_BITS (COORD_BITS),
        .COST_BITS  (COST_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_point_x    (s_axis_tdata[COORD_BITS-1:0]),
        .i_point_y    (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_last_point (s_axis_tlast),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_data   (m_axis_tdata)
    );

endmodule
`default_nettype wire

[verif/route_length_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// route_length_checker
// Watches both streams of the skip-checkpoint route engine. It keeps its own
// cost table and point window, works out the expected least route length for
// each route, and compares every output item against it.
// ---------------------------------------------------------------------------
module route_length_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [cspdp_pkg::SKIP_REG_BITS-1:0] i_cfg_wdata,
    input  wire logic                                i_pt_valid,
    input  wire logic                                i_pt_ready,
    // point_x, point_y
    input  wire logic [31:0]                         i_pt_data,
    input  wire logic                                i_pt_last,
    input  wire logic                                i_len_valid,
    input  wire logic                                i_len_ready,
    // min_length
    input  wire logic [cspdp_pkg::OUT_BITS-1:0]      i_len_data,
    output int                                       o_errors,
    output int                                       o_pending,
    output int                                       o_points,
    output int                                       o_routes
);

    localparam int WIN = cspdp_pkg::MAX_SKIPS_DEF + 1;
    localparam int CB  = cspdp_pkg::COORD_BITS_DEF;
    localparam int CW  = cspdp_pkg::COST_BITS_DEF;

    typedef logic [CW-1:0] t_cost;
    typedef logic signed [CB-1:0] t_coord;

    localparam t_cost UNREACHED = '1;

    // predictor state
    logic [cspdp_pkg::SKIP_REG_BITS-1:0] skip_limit;
    t_coord                              win_x [WIN];
    t_coord                              win_y [WIN];
    t_cost                               cost_tbl [WIN][WIN];
    int unsigned                         seen_pts;
    logic [cspdp_pkg::OUT_BITS-1:0]      expected_lengths [$];

    // sum that sticks at all ones
    function automatic t_cost add_sat(t_cost a, t_cost b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? UNREACHED : s[CW-1:0];
    endfunction

    // manhattan distance between two points
    function automatic t_cost hop_len(t_coord ax, t_coord ay, t_coord bx, t_coord by);
        logic signed [CB+1:0] dx;
        logic signed [CB+1:0] dy;
        dx = ax - bx;
        dy = ay - by;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return t_cost'(dx) + t_cost'(dy);
    endfunction

    task automatic clear_route();
        foreach (cost_tbl[i, j]) cost_tbl[i][j] = UNREACHED;
        seen_pts = 0;
    endtask

    // one point of the route: new cost row, then either the result or a shift
    task automatic advance_route(input t_coord px, input t_coord py, input logic is_last);
        t_cost       row [WIN];
        t_cost       cand;
        t_cost       best;
        int unsigned lim;
        lim = skip_limit;
        if (lim > WIN - 1) lim = WIN - 1;
        foreach (row[j]) row[j] = UNREACHED;
        if (seen_pts == 0) begin
            row[0] = '0;
        end else begin
            // column j reached from window point p-1 having skipped p-1 points on the hop
            for (int j = 0; j <= lim; j++) begin
                for (int p = 1; p <= j + 1 && p <= seen_pts; p++) begin
                    if (cost_tbl[p-1][j+1-p] != UNREACHED) begin
                        cand = add_sat(cost_tbl[p-1][j+1-p],
                                       hop_len(px, py, win_x[p-1], win_y[p-1]));
                        if (cand < row[j]) row[j] = cand;
                    end
                end
            end
        end
        if (is_last) begin
            best = UNREACHED;
            for (int j = 0; j <= lim; j++)
                if (row[j] < best) best = row[j];
            expected_lengths.push_back(best);
            o_routes++;
            clear_route();
        end else begin
            for (int i = WIN - 1; i > 0; i--) begin
                win_x[i]    = win_x[i-1];
                win_y[i]    = win_y[i-1];
                cost_tbl[i] = cost_tbl[i-1];
            end
            win_x[0]    = px;
            win_y[0]    = py;
            cost_tbl[0] = row;
            if (seen_pts < WIN) seen_pts++;
        end
    endtask

    // sample both channels and the register port
    always @(posedge i_clk) begin : watch
        logic [cspdp_pkg::OUT_BITS-1:0] want;
        if (!i_rst_n) begin
            skip_limit = '0;
            clear_route();
            expected_lengths.delete();
        end else begin
            if (i_cfg_we) skip_limit = i_cfg_wdata;
            // results first, they belong to earlier items
            if (i_len_valid && i_len_ready) begin
                if (expected_lengths.size() == 0) begin
                    $error("min_length: unexpected result, actual %0d", i_len_data);
                    o_errors++;
                end else begin
                    want = expected_lengths.pop_front();
                    if (i_len_data !== want) begin
                        $error("min_length: expected %0d, actual %0d", want, i_len_data);
                        o_errors++;
                    end
                end
            end
            if (i_pt_valid && i_pt_ready) begin
                advance_route(i_pt_data[15:0], i_pt_data[31:16], i_pt_last);
                o_points++;
            end
        end
        o_pending = expected_lengths.size();
    end

endmodule

[verif/checkpoint_skip_path_dp_core_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// checkpoint_skip_path_dp_core_test
// Drives routes of points into the skip-checkpoint route engine: a directed
// opening with coordinate extremes, single-point routes and a skip limit
// changed inside a route, then random routes over many skip limits with
// bursty input, output stalls and one long output hold-off.
// ---------------------------------------------------------------------------
module checkpoint_skip_path_dp_core_test;

    localparam int IDLE_LIMIT     = 20000;
    localparam int DRAIN_CYCLES   = 160;
    localparam int RX_HOLD_CYCLES = 3000;
    localparam int TARGET_ITEMS   = 1550;

    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                i_cfg_we      = 1'b0;
    logic [cspdp_pkg::SKIP_REG_BITS-1:0] i_cfg_wdata   = '0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    // point_x, point_y
    logic [31:0]                         s_axis_tdata  = '0;
    logic                                s_axis_tlast  = 1'b0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    // min_length
    logic [cspdp_pkg::OUT_BITS-1:0]      m_axis_tdata;

    int  tally_errors;
    int  tally_pending;
    int  tally_points;
    int  tally_routes;
    int  items_sent  = 0;
    int  cfg_writes  = 0;
    int  burst_left  = 0;
    bit  no_gaps     = 1'b0;
    bit  rx_hold_req = 1'b0;
    logic in_taken   = 1'b0;
    int  idle_cycles = 0;

    always #2 i_clk = ~i_clk;

    checkpoint_skip_path_dp_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    route_length_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pt_valid  (s_axis_tvalid),
        .i_pt_ready  (s_axis_tready),
        .i_pt_data   (s_axis_tdata),
        .i_pt_last   (s_axis_tlast),
        .i_len_valid (m_axis_tvalid),
        .i_len_ready (m_axis_tready),
        .i_len_data  (m_axis_tdata),
        .o_errors    (tally_errors),
        .o_pending   (tally_pending),
        .o_points    (tally_points),
        .o_routes    (tally_routes)
    );

    // input handshake seen at the rising edge, read back at the falling one
    always @(posedge i_clk) begin
        in_taken <= s_axis_tvalid && s_axis_tready;
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("** checkpoint_skip_path_dp_core: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // output side: stall modes chosen at random, plus one long hold
    initial begin : receiver
        int rx_cyc;
        int rx_mode;
        bit hold_used;
        rx_cyc    = 0;
        rx_mode   = 0;
        hold_used = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req && !hold_used) begin
                hold_used     = 1'b1;
                m_axis_tready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
            end
            if (rx_cyc % 300 == 0) rx_mode = $urandom_range(0, 2);
            rx_cyc++;
            case (rx_mode)
                0: m_axis_tready = 1'b1;
                1: m_axis_tready = (rx_cyc % 7) < 3;
                default: m_axis_tready = 1'($urandom_range(0, 1));
            endcase
        end
    end

    // random gap between bursts of items
    task automatic pace_sender();
        if (!no_gaps && burst_left == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
    endtask

    task automatic send_point(input logic [15:0] px, input logic [15:0] py, input logic is_last);
        pace_sender();
        s_axis_tdata  = {py, px};
        s_axis_tlast  = is_last;
        s_axis_tvalid = 1'b1;
        @(negedge i_clk);
        while (!in_taken) @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        items_sent++;
    endtask

    // hold input until every result is back and the engine has settled
    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (tally_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_skip(input logic [cspdp_pkg::SKIP_REG_BITS-1:0] limit);
        wait_idle();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = limit;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        cfg_writes++;
    endtask

    // mostly short hops, some full-range values and corners
    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 9))
            0, 1: return 16'($urandom);
            2: begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h0000;
                    default: return 16'hffff;
                endcase
            end
            default: return 16'($urandom_range(0, 400) - 200);
        endcase
    endfunction

    task automatic send_route(input int n_pts);
        for (int i = 0; i < n_pts; i++)
            send_point(pick_coord(), pick_coord(), i == n_pts - 1);
    endtask

    initial begin : stimulus
        int phase;
        int n_routes;
        int pick;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // single-point route under the reset skip limit
        send_point(16'h8000, 16'h7fff, 1'b1);

        // no skipping, corner coordinates
        write_skip(0);
        send_point(16'h7fff, 16'h7fff, 1'b0);
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h7fff, 16'h8000, 1'b1);

        // widest skip limit, zigzag where skipping pays off
        write_skip(15);
        for (int i = 0; i < 12; i++)
            send_point((i % 2) ? 16'h7fff - 16'(i) : 16'(i * 3),
                       (i % 3 == 0) ? 16'h8000 : 16'(i * 7), i == 11);

        // skip limit changed inside a route
        send_point(16'd10, 16'd10, 1'b0);
        send_point(16'd1000, -16'sd1000, 1'b0);
        send_point(16'd20, 16'd20, 1'b0);
        send_point(-16'sd5, 16'd3, 1'b0);
        write_skip(1);
        send_point(16'd30, 16'd30, 1'b0);
        send_point(16'd40, -16'sd40, 1'b1);

        // random phases, each with its own skip limit and pacing
        phase = 0;
        while (items_sent < TARGET_ITEMS) begin
            case (phase)
                0: write_skip(15);
                1: write_skip(0);
                default: write_skip(4'($urandom_range(0, 15)));
            endcase
            no_gaps = (phase == 3) || ($urandom_range(0, 3) == 0);
            if (phase == 3) begin
                // quick results under the hold: one parks at the output, the next backs up input
                rx_hold_req = 1'b1;
                send_route(1);
                send_route(1);
            end
            n_routes = $urandom_range(3, 8);
            repeat (n_routes) begin
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    send_route(1);
                else if (pick < 8)
                    send_route($urandom_range(2, 12));
                else
                    send_route($urandom_range(13, 40));
            end
            phase++;
        end

        wait_idle();
        $display("run checked %0d points in %0d routes over %0d skip-limit writes (0 to 15)",
                 tally_points, tally_routes, cfg_writes);
        $display("with single-point and window-overflowing routes, bursty input and a long output hold");
        if (tally_errors == 0 && tally_pending == 0) begin
            $display("** checkpoint_skip_path_dp_core: PASSED **");
        end else begin
            if (tally_pending != 0) $error("min_length: %0d results never arrived", tally_pending);
            $display("** checkpoint_skip_path_dp_core: FAILED **");
        end
        $finish;
    end

endmodule
